[src/tssm_pkg.sv]
// ----------------------------------------------------------------------------
// tssm_pkg: types and constants for three stacks in one shared memory
// Word layouts, action codes and store geometry used by the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tssm_pkg;

  // Store geometry
  localparam int DEPTH       = 64;
  localparam int NUM_STACKS  = 3;
  localparam int STORE_WORDS = NUM_STACKS * DEPTH;
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CAP_W       = 7;
  localparam int SEL_W       = 2;
  localparam int DATA_W      = 32;
  // Wide enough for base + count
  localparam int SUM_W       = ADDR_W + 1;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(64);
  localparam logic [SEL_W-1:0]  SEL_MAX   = SEL_W'(NUM_STACKS - 1);
  localparam logic [DATA_W-1:0] NEG_ONE   = {DATA_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  typedef struct packed {
    action_t                   action;
    logic [SEL_W-1:0]          stack_sel;
    logic signed [DATA_W-1:0]  push_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  read_value;
    logic                      stack_empty;
    logic                      push_dropped;
  } rsp_t;

endpackage

`default_nettype wire

[src/three_stacks_shared_memory.sv]
// ----------------------------------------------------------------------------
// three_stacks_shared_memory: three bounded stacks in one word store
// Push, pop, peek and emptiness query on one of three stacks per word.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake         | word
//  --------+-----------+-------------------+------------------------------
//  req     | in        | req_valid/stall   | action, stack_sel, push_value
//  rsp     | out       | rsp_valid/stall   | read_value, stack_empty, dropped
//  cfg     | in        | cfg_valid/ready   | stack capacity (7 bits)
//
//  One request word per cycle sustained while req_stall is low; a response
//  is registered in the store read stage, then in the output register.
//  Fill counts update at acceptance and the store is written at the same
//  edge, so a pop straight after a push reads the freshly written word.
//  Reset clears the fill counts and sets capacity to 64; no clearing pass.
//  A stall on rsp backs up through the read stage into req_stall.
//
`default_nettype none

module three_stacks_shared_memory (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output      logic           req_stall,
  input  wire tssm_pkg::req_t req,
  output      logic           rsp_valid,
  input  wire logic           rsp_stall,
  output      tssm_pkg::rsp_t rsp,
  input  wire logic           cfg_valid,
  output      logic           cfg_ready,
  input  wire logic [tssm_pkg::CAP_W-1:0] cfg_data
);

  // Store and control state
  logic [tssm_pkg::DATA_W-1:0] store [tssm_pkg::STORE_WORDS];
  logic [tssm_pkg::DATA_W-1:0] rdata;
  logic [tssm_pkg::CNT_W-1:0]  fill_count [tssm_pkg::NUM_STACKS];
  logic [tssm_pkg::CAP_W-1:0]  capacity;

  logic s1_valid;
  logic s1_use_mem;
  logic s1_neg;
  logic s1_empty;
  logic s1_dropped;

  logic                        accept;
  logic                        s1_move;
  logic [tssm_pkg::SEL_W-1:0]  sel;
  logic [tssm_pkg::CNT_W-1:0]  cap_eff;
  logic [tssm_pkg::CNT_W-1:0]  cnt;
  logic [tssm_pkg::SUM_W-1:0]  base;
  logic [tssm_pkg::SUM_W-1:0]  wr_addr;
  logic [tssm_pkg::SUM_W-1:0]  rd_addr;
  logic                        is_empty;
  logic                        is_full;
  logic                        do_push;
  logic                        do_read;
  logic                        do_pop;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign s1_move   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !s1_move;
  assign accept    = req_valid && !req_stall;

  // Decode: stack, effective capacity, region base
  always_comb begin
    sel = (req.stack_sel > tssm_pkg::SEL_MAX) ? tssm_pkg::SEL_MAX : req.stack_sel;
    cap_eff = (32'(capacity) > 32'(tssm_pkg::DEPTH)) ?
              tssm_pkg::CNT_W'(tssm_pkg::DEPTH) : tssm_pkg::CNT_W'(capacity);
    cnt = fill_count[sel];
    unique case (sel)
      2'd0:    base = '0;
      2'd1:    base = tssm_pkg::SUM_W'(cap_eff);
      default: base = tssm_pkg::SUM_W'(cap_eff) << 1;
    endcase
    wr_addr  = base + tssm_pkg::SUM_W'(cnt);
    rd_addr  = wr_addr - tssm_pkg::SUM_W'(1);
    is_empty = (cnt == '0);
    is_full  = (cnt >= cap_eff);
    do_push  = accept && (req.action == tssm_pkg::ACT_PUSH) && !is_full;
    do_read  = accept && !is_empty &&
               ((req.action == tssm_pkg::ACT_POP) || (req.action == tssm_pkg::ACT_PEEK));
    do_pop   = do_read && (req.action == tssm_pkg::ACT_POP);
  end

  // Shared store: write on push, registered read on pop/peek
  always_ff @(posedge clk) begin
    if (do_push && (wr_addr < tssm_pkg::SUM_W'(tssm_pkg::STORE_WORDS))) begin
      store[wr_addr[tssm_pkg::ADDR_W-1:0]] <= req.push_value;
    end
    if (do_read) begin
      rdata <= store[rd_addr[tssm_pkg::ADDR_W-1:0]];
    end
  end

  // Capacity register and fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= tssm_pkg::CAP_RESET;
      for (int i = 0; i < tssm_pkg::NUM_STACKS; i++) begin
        fill_count[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (do_push) begin
        fill_count[sel] <= cnt + tssm_pkg::CNT_W'(1);
      end else if (do_pop) begin
        fill_count[sel] <= cnt - tssm_pkg::CNT_W'(1);
      end
    end
  end

  // Read stage flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_use_mem <= do_read;
      s1_neg     <= is_empty &&
                    ((req.action == tssm_pkg::ACT_POP) || (req.action == tssm_pkg::ACT_PEEK));
      s1_empty   <= is_empty;
      s1_dropped <= (req.action == tssm_pkg::ACT_PUSH) && is_full;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_move) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp.read_value   <= s1_use_mem ? rdata : (s1_neg ? tssm_pkg::NEG_ONE : '0);
      rsp.stack_empty  <= s1_empty;
      rsp.push_dropped <= s1_dropped;
    end
  end

`ifndef SYNTHESIS
  // Fill counts never pass the store depth per stack
  assert property (@(posedge clk) disable iff (rst)
    (fill_count[0] <= tssm_pkg::CNT_W'(tssm_pkg::DEPTH)) &&
    (fill_count[1] <= tssm_pkg::CNT_W'(tssm_pkg::DEPTH)) &&
    (fill_count[2] <= tssm_pkg::CNT_W'(tssm_pkg::DEPTH)))
    else $error("fill count beyond depth");

  // Held read stage keeps its store data
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> $stable(rdata))
    else $error("read data lost while held");

  // A dropped push never carries read data
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.push_dropped) |-> (rsp.read_value == '0))
    else $error("dropped push with non-zero read value");
`endif

endmodule

`default_nettype wire
